// ----- sv/lwbsc_pkg.sv -----
// Shared types and constants of the LRU write-back sector cache controller.
package lwbsc_pkg;

    localparam int LINES        = 64;
    localparam int SECTOR_BYTES = 512;
    localparam int SLOT_W       = $clog2(LINES);
    localparam int OUT_SLOT_W   = 6;
    localparam int SECTOR_W     = 32;
    localparam int OFF_W        = 9;
    localparam int CNT_W        = 10;
    localparam int CTR_W        = 32;
    localparam int IN_W         = 56;
    localparam int OUT_W        = 176;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_INVAL = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SECTOR_W-1:0] tag;
        logic                valid;
        logic                dirty;
    } line_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] key_sector;
        logic                shift;
        logic [SLOT_W-1:0]   pos;
        line_t               load;
        logic [SLOT_W-1:0]   flush_slot;
        logic                clear_dirty;
        logic                clear_all;
    } cell_ctrl_t;

    typedef struct packed {
        logic tag_hit;
        logic slot_hit;
        logic dirty;
    } cell_stat_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                wb_valid;
        logic [SECTOR_W-1:0] wb_sector;
        logic                fetch;
        logic                last;
        logic [CTR_W-1:0]    hit_total;
        logic [CTR_W-1:0]    miss_total;
        logic [CTR_W-1:0]    wb_total;
        logic [CTR_W-1:0]    fetch_total;
    } result_t;

endpackage

// ----- sv/lwbsc_cell.sv -----
// One position of the recency chain, holding a line's slot, tag, valid and dirty bits.
module lwbsc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lwbsc_pkg::SLOT_W-1:0] init_slot,
    input  logic                       shift,
    input  lwbsc_pkg::line_t           nb,
    input  lwbsc_pkg::cell_ctrl_t      ctl,
    output lwbsc_pkg::line_t           line,
    output lwbsc_pkg::cell_stat_t      stat
);

    logic [lwbsc_pkg::SLOT_W-1:0]   slot_reg;
    logic [lwbsc_pkg::SECTOR_W-1:0] tag_reg;
    logic                           valid_reg;
    logic                           dirty_reg;
    logic                           slot_match;

    assign slot_match = (slot_reg == ctl.flush_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= init_slot;
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else if (shift)
        begin
            slot_reg  <= nb.slot;
            valid_reg <= nb.valid;
            dirty_reg <= nb.dirty;
        end
        else if (ctl.clear_all)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else if (ctl.clear_dirty && slot_match)
        begin
            dirty_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tag_reg <= nb.tag;
        end
    end

    assign line.slot  = slot_reg;
    assign line.tag   = tag_reg;
    assign line.valid = valid_reg;
    assign line.dirty = dirty_reg;

    assign stat.tag_hit  = valid_reg && (tag_reg == ctl.key_sector);
    assign stat.slot_hit = slot_match;
    assign stat.dirty    = valid_reg && dirty_reg;

endmodule

// ----- sv/lwbsc_ctrl.sv -----
// Sequencer of the cache controller: lookup, recency update, flush scan, counters and result register.
module lwbsc_ctrl (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  lwbsc_pkg::cmd_t                            in_cmd,
    input  logic [lwbsc_pkg::SECTOR_W-1:0]             in_sector,
    input  logic [lwbsc_pkg::OFF_W-1:0]                in_offset,
    input  logic [lwbsc_pkg::CNT_W-1:0]                in_count,
    input  lwbsc_pkg::line_t    [lwbsc_pkg::LINES-1:0] lines,
    input  lwbsc_pkg::cell_stat_t [lwbsc_pkg::LINES-1:0] stats,
    output lwbsc_pkg::cell_ctrl_t                      cc,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output lwbsc_pkg::result_t                         out_res
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_FLUSH  = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [lwbsc_pkg::SLOT_W-1:0]   scan_reg, scan_next;
    logic [lwbsc_pkg::CTR_W-1:0]    hit_ctr_reg, hit_ctr_next;
    logic [lwbsc_pkg::CTR_W-1:0]    miss_ctr_reg, miss_ctr_next;
    logic [lwbsc_pkg::CTR_W-1:0]    wb_ctr_reg, wb_ctr_next;
    logic [lwbsc_pkg::CTR_W-1:0]    fetch_ctr_reg, fetch_ctr_next;
    logic                           out_valid_reg, out_valid_next;
    lwbsc_pkg::result_t             res_reg, res_next;

    lwbsc_pkg::cmd_t                cmd_reg;
    logic [lwbsc_pkg::SECTOR_W-1:0] sector_reg;
    logic                           hit_reg;
    logic                           full_reg;
    logic [lwbsc_pkg::SLOT_W-1:0]   pos_reg;
    lwbsc_pkg::line_t               sel_reg;

    logic                           hit_any;
    logic [lwbsc_pkg::SLOT_W-1:0]   hit_pos;
    lwbsc_pkg::line_t               hit_line;
    logic                           whole_write;
    logic                           any_dirty;
    logic                           other_dirty;
    logic                           scan_dirty;
    logic [lwbsc_pkg::SECTOR_W-1:0] scan_tag;
    logic                           out_free;
    logic                           accept;
    logic                           is_write;
    logic                           miss_wb;
    logic                           miss_fetch;

    function automatic logic [lwbsc_pkg::CTR_W-1:0] CTR_ONE(input logic b);
        CTR_ONE = {{(lwbsc_pkg::CTR_W-1){1'b0}}, b};
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign is_write = (cmd_reg == lwbsc_pkg::CMD_WRITE);

    assign whole_write = (in_cmd == lwbsc_pkg::CMD_WRITE) && (in_offset == '0) &&
                         (32'(in_count) >= 32'(lwbsc_pkg::SECTOR_BYTES));

    always_comb
    begin
        hit_any     = 1'b0;
        hit_pos     = '0;
        hit_line    = '0;
        any_dirty   = 1'b0;
        other_dirty = 1'b0;
        scan_dirty  = 1'b0;
        scan_tag    = '0;
        for (int i = 0; i < lwbsc_pkg::LINES; i++)
        begin
            if (stats[i].tag_hit)
            begin
                hit_any  = 1'b1;
                hit_pos  = hit_pos | lwbsc_pkg::SLOT_W'(i);
                hit_line = hit_line | lines[i];
            end
            any_dirty = any_dirty | stats[i].dirty;
            if (stats[i].slot_hit)
            begin
                scan_dirty = scan_dirty | stats[i].dirty;
                scan_tag   = scan_tag | lines[i].tag;
            end
            else
            begin
                other_dirty = other_dirty | stats[i].dirty;
            end
        end
    end

    assign miss_wb    = !hit_reg && sel_reg.valid && sel_reg.dirty;
    assign miss_fetch = !hit_reg && !full_reg;

    always_comb
    begin
        cc             = '0;
        cc.key_sector  = in_sector;
        cc.pos         = pos_reg;
        cc.flush_slot  = scan_reg;
        cc.load.slot   = sel_reg.slot;
        cc.load.tag    = hit_reg ? sel_reg.tag : sector_reg;
        cc.load.valid  = 1'b1;
        cc.load.dirty  = (hit_reg && sel_reg.dirty) || is_write;
        state_next     = state_reg;
        scan_next      = scan_reg;
        hit_ctr_next   = hit_ctr_reg;
        miss_ctr_next  = miss_ctr_reg;
        wb_ctr_next    = wb_ctr_reg;
        fetch_ctr_next = fetch_ctr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    scan_next = '0;
                    if (in_cmd == lwbsc_pkg::CMD_READ || in_cmd == lwbsc_pkg::CMD_WRITE)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cc.shift       = 1'b1;
                    hit_ctr_next   = hit_ctr_reg + CTR_ONE(hit_reg);
                    miss_ctr_next  = miss_ctr_reg + CTR_ONE(!hit_reg);
                    wb_ctr_next    = wb_ctr_reg + CTR_ONE(miss_wb);
                    fetch_ctr_next = fetch_ctr_reg + CTR_ONE(miss_fetch);
                    res_next.slot        = sel_reg.slot;
                    res_next.hit         = hit_reg;
                    res_next.wb_valid    = miss_wb;
                    res_next.wb_sector   = miss_wb ? sel_reg.tag : '0;
                    res_next.fetch       = miss_fetch;
                    res_next.last        = 1'b1;
                    res_next.hit_total   = hit_ctr_next;
                    res_next.miss_total  = miss_ctr_next;
                    res_next.wb_total    = wb_ctr_next;
                    res_next.fetch_total = fetch_ctr_next;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (!any_dirty)
                    begin
                        if (cmd_reg == lwbsc_pkg::CMD_INVAL)
                        begin
                            cc.clear_all   = 1'b1;
                            hit_ctr_next   = '0;
                            miss_ctr_next  = '0;
                            wb_ctr_next    = '0;
                            fetch_ctr_next = '0;
                        end
                        res_next             = '0;
                        res_next.last        = 1'b1;
                        res_next.hit_total   = hit_ctr_next;
                        res_next.miss_total  = miss_ctr_next;
                        res_next.wb_total    = wb_ctr_next;
                        res_next.fetch_total = fetch_ctr_next;
                        out_valid_next       = 1'b1;
                        state_next           = ST_IDLE;
                    end
                    else if (scan_dirty)
                    begin
                        cc.clear_dirty       = 1'b1;
                        res_next             = '0;
                        res_next.slot        = scan_reg;
                        res_next.wb_valid    = 1'b1;
                        res_next.wb_sector   = scan_tag;
                        res_next.last        = !other_dirty;
                        res_next.hit_total   = hit_ctr_reg;
                        res_next.miss_total  = miss_ctr_reg;
                        res_next.wb_total    = wb_ctr_reg + CTR_ONE(1'b1);
                        res_next.fetch_total = fetch_ctr_reg;
                        wb_ctr_next          = wb_ctr_reg + CTR_ONE(1'b1);
                        out_valid_next       = 1'b1;
                        scan_next            = scan_reg + 1'b1;
                        if (!other_dirty)
                        begin
                            state_next = ST_IDLE;
                            if (cmd_reg == lwbsc_pkg::CMD_INVAL)
                            begin
                                cc.clear_all   = 1'b1;
                                hit_ctr_next   = '0;
                                miss_ctr_next  = '0;
                                wb_ctr_next    = '0;
                                fetch_ctr_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            hit_ctr_reg   <= '0;
            miss_ctr_reg  <= '0;
            wb_ctr_reg    <= '0;
            fetch_ctr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            hit_ctr_reg   <= hit_ctr_next;
            miss_ctr_reg  <= miss_ctr_next;
            wb_ctr_reg    <= wb_ctr_next;
            fetch_ctr_reg <= fetch_ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            cmd_reg    <= in_cmd;
            sector_reg <= in_sector;
            hit_reg    <= hit_any;
            full_reg   <= whole_write;
            pos_reg    <= hit_any ? hit_pos : '0;
            sel_reg    <= hit_any ? hit_line : lines[0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- sv/lru_write_back_sector_cache_control.sv -----
// Top level of the LRU write-back sector cache controller: stream ports and the chain of line cells.
// A read or write access is taken while idle and its result is registered once the output is free,
// before another access is taken; the lookup compares every cell of the recency chain at once.
// Flush and invalidate scan one slot per cycle while no pending result is held back, and finish
// once no dirty line remains.
// Reset is asynchronous and active low: lines become invalid and clean, the recency chain
// holds slots in order and the counters are zero; tags stay undefined and no clearing pass runs.
module lru_write_back_sector_cache_control (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command, sector, byte_offset, byte_count
    input  logic [lwbsc_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot, hit, writeback_valid, writeback_sector, fetch_valid,
    // hit_total, miss_total, writeback_total, fetch_total
    output logic [lwbsc_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tlast
);

    lwbsc_pkg::line_t      [lwbsc_pkg::LINES-1:0] lines;
    lwbsc_pkg::cell_stat_t [lwbsc_pkg::LINES-1:0] stats;
    lwbsc_pkg::cell_ctrl_t                        cc;
    lwbsc_pkg::result_t                           res;

    lwbsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (lwbsc_pkg::cmd_t'(s_axis_tdata[1:0])),
        .in_sector (s_axis_tdata[33:2]),
        .in_offset (s_axis_tdata[42:34]),
        .in_count  (s_axis_tdata[52:43]),
        .lines     (lines),
        .stats     (stats),
        .cc        (cc),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    for (genvar i = 0; i < lwbsc_pkg::LINES; i++)
    begin : g_cell
        lwbsc_pkg::line_t nb;
        logic             shift;

        if (i == lwbsc_pkg::LINES - 1)
        begin : g_tail
            assign nb = cc.load;
        end
        else
        begin : g_body
            assign nb = lines[i+1];
        end

        assign shift = cc.shift && (lwbsc_pkg::SLOT_W'(i) >= cc.pos);

        lwbsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .init_slot (lwbsc_pkg::SLOT_W'(i)),
            .shift     (shift),
            .nb        (nb),
            .ctl       (cc),
            .line      (lines[i]),
            .stat      (stats[i])
        );
    end

    assign m_axis_tdata = {7'd0, res.fetch_total, res.wb_total, res.miss_total, res.hit_total,
                           res.fetch, res.wb_sector, res.wb_valid, res.hit,
                           lwbsc_pkg::OUT_SLOT_W'(res.slot)};
    assign m_axis_tlast = res.last;

endmodule
